// ===== hw/rtl/ufmc_pkg.sv =====
package ufmc_pkg;

  // field widths
  localparam int CELL_W = 10;
  localparam int SIDE_W = 6;
  localparam int RANK_W = 4;
  localparam int MARK_W = 2;
  localparam int NB_W   = CELL_W + 1;
  localparam int AREA_W = 2 * SIDE_W;

  localparam int MAX_CELLS_DEF = 1024;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = SIDE_W'(32);
  localparam logic [RANK_W-1:0] RANK_MAX      = RANK_W'(15);

  localparam logic [MARK_W-1:0] WALL_EAST  = 2'b01;
  localparam logic [MARK_W-1:0] WALL_SOUTH = 2'b10;
  localparam logic [MARK_W-1:0] WALLS_BOTH = WALL_EAST | WALL_SOUTH;

  // remainder unit: one quotient bit per step
  localparam int                DIVC_W    = $clog2(CELL_W + 1);
  localparam logic [DIVC_W-1:0] DIV_STEPS = DIVC_W'(CELL_W);

  // microprogram
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 5'd0;
  localparam step_t STEP_DISPATCH = 5'd1;
  localparam step_t STEP_CHK      = 5'd2;
  localparam step_t STEP_MARKS    = 5'd3;
  localparam step_t STEP_DIV      = 5'd4;
  localparam step_t STEP_NB       = 5'd5;
  localparam step_t STEP_NBCHK    = 5'd6;
  localparam step_t STEP_WA       = 5'd7;
  localparam step_t STEP_WB_RD    = 5'd8;
  localparam step_t STEP_WB       = 5'd9;
  localparam step_t STEP_RANK_A   = 5'd10;
  localparam step_t STEP_RANK_B   = 5'd11;
  localparam step_t STEP_MERGE    = 5'd12;
  localparam step_t STEP_CLEAR    = 5'd13;
  localparam step_t STEP_CLR      = 5'd14;
  localparam step_t STEP_FIN      = 5'd15;
  localparam step_t STEP_RET      = 5'd16;
  localparam step_t STEP_BOOT     = 5'd17;
  localparam step_t STEP_BOOT_CLR = 5'd18;
  localparam step_t STEP_BOOT_END = 5'd19;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_CHECK,
    UOP_RD_WALL,
    UOP_LOAD_MARKS,
    UOP_DIV_STEP,
    UOP_NEIGHBOUR,
    UOP_RD_A,
    UOP_WALK_A,
    UOP_RD_B,
    UOP_WALK_B,
    UOP_RD_RANK_A,
    UOP_RD_RANK_B,
    UOP_MERGE,
    UOP_CLR_INIT,
    UOP_CLR_WRITE,
    UOP_FINISH
  } uop_t;

  typedef enum logic [3:0] {
    UC_NEXT,
    UC_ALWAYS,
    UC_NO_ITEM,
    UC_CMD,
    UC_BAD,
    UC_DIV_BUSY,
    UC_NOT_ROOT,
    UC_SAME,
    UC_SWEEP_BUSY,
    UC_OUT_BUSY
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    step_t  target;
  } uword_t;

  typedef struct packed {
    logic no_item;
    logic cmd;
    logic bad;
    logic div_busy;
    logic not_root;
    logic same;
    logic sweep_busy;
    logic out_busy;
  } dp_status_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '{op: UOP_NONE, cond: UC_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE:     w = '{op: UOP_ACCEPT,     cond: UC_NO_ITEM,    target: STEP_IDLE};
      STEP_DISPATCH: w = '{op: UOP_CHECK,      cond: UC_CMD,        target: STEP_CLEAR};
      STEP_CHK:      w = '{op: UOP_RD_WALL,    cond: UC_BAD,        target: STEP_FIN};
      STEP_MARKS:    w = '{op: UOP_LOAD_MARKS, cond: UC_NEXT,       target: STEP_IDLE};
      STEP_DIV:      w = '{op: UOP_DIV_STEP,   cond: UC_DIV_BUSY,   target: STEP_DIV};
      STEP_NB:       w = '{op: UOP_NEIGHBOUR,  cond: UC_NEXT,       target: STEP_IDLE};
      STEP_NBCHK:    w = '{op: UOP_RD_A,       cond: UC_BAD,        target: STEP_FIN};
      STEP_WA:       w = '{op: UOP_WALK_A,     cond: UC_NOT_ROOT,   target: STEP_WA};
      STEP_WB_RD:    w = '{op: UOP_RD_B,       cond: UC_NEXT,       target: STEP_IDLE};
      STEP_WB:       w = '{op: UOP_WALK_B,     cond: UC_NOT_ROOT,   target: STEP_WB};
      STEP_RANK_A:   w = '{op: UOP_RD_RANK_A,  cond: UC_SAME,       target: STEP_FIN};
      STEP_RANK_B:   w = '{op: UOP_RD_RANK_B,  cond: UC_NEXT,       target: STEP_IDLE};
      STEP_MERGE:    w = '{op: UOP_MERGE,      cond: UC_ALWAYS,     target: STEP_FIN};
      STEP_CLEAR:    w = '{op: UOP_CLR_INIT,   cond: UC_NEXT,       target: STEP_IDLE};
      STEP_CLR:      w = '{op: UOP_CLR_WRITE,  cond: UC_SWEEP_BUSY, target: STEP_CLR};
      STEP_FIN:      w = '{op: UOP_FINISH,     cond: UC_OUT_BUSY,   target: STEP_FIN};
      STEP_RET:      w = '{op: UOP_NONE,       cond: UC_ALWAYS,     target: STEP_IDLE};
      STEP_BOOT:     w = '{op: UOP_CLR_INIT,   cond: UC_NEXT,       target: STEP_IDLE};
      STEP_BOOT_CLR: w = '{op: UOP_CLR_WRITE,  cond: UC_SWEEP_BUSY, target: STEP_BOOT_CLR};
      STEP_BOOT_END: w = '{op: UOP_NONE,       cond: UC_ALWAYS,     target: STEP_IDLE};
      default:       w = '{op: UOP_NONE,       cond: UC_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/ufmc_ram.sv =====
module ufmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ufmc_seq.sv =====
module ufmc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ufmc_pkg::dp_status_t status,
  output ufmc_pkg::uword_t     ctrl
);
  import ufmc_pkg::*;

  step_t  upc_r;
  step_t  upc_nxt;
  uword_t uw;
  logic   take;

  assign uw   = ucode_rom(upc_r);
  assign ctrl = uw;

  always_comb begin
    case (uw.cond)
      UC_NEXT:       take = 1'b0;
      UC_ALWAYS:     take = 1'b1;
      UC_NO_ITEM:    take = status.no_item;
      UC_CMD:        take = status.cmd;
      UC_BAD:        take = status.bad;
      UC_DIV_BUSY:   take = status.div_busy;
      UC_NOT_ROOT:   take = status.not_root;
      UC_SAME:       take = status.same;
      UC_SWEEP_BUSY: take = status.sweep_busy;
      UC_OUT_BUSY:   take = status.out_busy;
      default:       take = 1'b0;
    endcase
    upc_nxt = take ? uw.target : upc_r + 1'b1;
  end

  // reset enters the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_BOOT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== hw/rtl/ufmc_dp.sv =====
module ufmc_dp #(
  parameter int MAX_CELLS = ufmc_pkg::MAX_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ufmc_pkg::uword_t              ctrl,
  input  logic [ufmc_pkg::SIDE_W-1:0]   grid_side,
  input  logic                          in_tvalid,
  input  logic                          in_cmd,
  input  logic [ufmc_pkg::CELL_W-1:0]   in_cell,
  input  logic                          in_south,
  input  logic                          out_tready,
  output ufmc_pkg::dp_status_t          status,
  output logic                          out_valid,
  output logic [ufmc_pkg::CELL_W-1:0]   out_cell,
  output logic [ufmc_pkg::MARK_W-1:0]   out_marks,
  output logic                          out_removed,
  output logic                          out_bad
);
  import ufmc_pkg::*;

  localparam int            AW        = $clog2(MAX_CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(MAX_CELLS - 1);

  logic              cmd_r, south_r, bad_r, removed_r;
  logic [CELL_W-1:0] cell_r, dvd_r;
  logic [MARK_W-1:0] marks_r;
  logic [SIDE_W-1:0] rem_r;
  logic [DIVC_W-1:0] cnt_r;
  logic [AW-1:0]     nb_r, cur_r, ra_r, rb_r, sweep_r;
  logic [RANK_W-1:0] rank_a_r;

  logic              out_valid_r, out_removed_r, out_bad_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [MARK_W-1:0] out_marks_r;

  logic [AW-1:0]     cell_a;
  logic [AREA_W-1:0] ncells;
  logic              outside;
  logic [NB_W-1:0]   sum_s, nb_sel;
  logic              bad_south, bad_east, nb_off;
  logic [SIDE_W:0]   trial;
  logic [SIDE_W-1:0] rem_step;
  logic              a_low, tie;
  logic [MARK_W-1:0] marks_cut;
  logic              out_busy;

  logic              p_we, r_we, w_we;
  logic [AW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;
  logic [AW-1:0]     r_waddr, r_raddr, w_waddr, w_raddr;
  logic [RANK_W-1:0] r_wdata, r_rdata;
  logic [MARK_W-1:0] w_wdata, w_rdata;

  assign cell_a  = AW'(cell_r);
  assign ncells  = AREA_W'(grid_side) * AREA_W'(grid_side);
  assign outside = (AREA_W'(cell_r) >= ncells) || (int'(cell_r) >= MAX_CELLS);

  assign sum_s     = NB_W'(cell_r) + NB_W'(grid_side);
  assign bad_south = AREA_W'(sum_s) >= ncells;
  // last column: remainder of cell by side equals side - 1
  assign bad_east  = rem_r == (grid_side - 1'b1);
  assign nb_sel    = south_r ? sum_s : NB_W'(cell_r) + 1'b1;
  assign nb_off    = int'(nb_sel) >= MAX_CELLS;

  assign trial    = {rem_r, dvd_r[CELL_W-1]};
  assign rem_step = (trial >= {1'b0, grid_side}) ? SIDE_W'(trial - {1'b0, grid_side})
                                                 : trial[SIDE_W-1:0];

  assign a_low     = rank_a_r < r_rdata;
  assign tie       = rank_a_r == r_rdata;
  assign marks_cut = marks_r & ~(south_r ? WALL_SOUTH : WALL_EAST);
  assign out_busy  = out_valid_r && !out_tready;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = ra_r;
    p_wdata = rb_r;
    p_raddr = cur_r;
    r_we    = 1'b0;
    r_waddr = ra_r;
    r_wdata = rank_a_r + 1'b1;
    r_raddr = ra_r;
    w_we    = 1'b0;
    w_waddr = cell_a;
    w_wdata = marks_cut;
    w_raddr = cell_a;
    case (ctrl.op)
      UOP_RD_A:   p_raddr = cell_a;
      UOP_RD_B:   p_raddr = nb_r;
      // follow the pointer just read, one hop per cycle
      UOP_WALK_A,
      UOP_WALK_B: p_raddr = p_rdata;
      UOP_RD_RANK_B: r_raddr = rb_r;
      UOP_MERGE: begin
        p_we = 1'b1;
        if (a_low) begin
          p_waddr = ra_r;
          p_wdata = rb_r;
        end else begin
          p_waddr = rb_r;
          p_wdata = ra_r;
        end
        r_we = tie && (rank_a_r != RANK_MAX);
        w_we = 1'b1;
      end
      UOP_CLR_WRITE: begin
        p_we    = 1'b1;
        p_waddr = sweep_r;
        p_wdata = sweep_r;
        r_we    = 1'b1;
        r_waddr = sweep_r;
        r_wdata = '0;
        w_we    = 1'b1;
        w_waddr = sweep_r;
        w_wdata = WALLS_BOTH;
      end
      default: ;
    endcase
  end

  ufmc_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  ufmc_ram #(.WIDTH(RANK_W), .DEPTH(MAX_CELLS)) u_rank (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata)
  );

  ufmc_ram #(.WIDTH(MARK_W), .DEPTH(MAX_CELLS)) u_walls (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
  );

  always_ff @(posedge clk) begin
    case (ctrl.op)
      UOP_ACCEPT: begin
        if (in_tvalid) begin
          cmd_r   <= in_cmd;
          cell_r  <= in_cell;
          south_r <= in_south;
        end
      end
      UOP_CHECK: begin
        bad_r     <= outside;
        marks_r   <= '0;
        removed_r <= 1'b0;
      end
      UOP_LOAD_MARKS: begin
        marks_r <= w_rdata;
        rem_r   <= '0;
        dvd_r   <= cell_r;
        cnt_r   <= DIV_STEPS;
      end
      UOP_DIV_STEP: begin
        rem_r <= rem_step;
        dvd_r <= {dvd_r[CELL_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      UOP_NEIGHBOUR: begin
        bad_r <= (south_r ? bad_south : bad_east) || nb_off;
        nb_r  <= AW'(nb_sel);
      end
      UOP_RD_A: cur_r <= cell_a;
      UOP_RD_B: cur_r <= nb_r;
      UOP_WALK_A: begin
        cur_r <= p_rdata;
        ra_r  <= cur_r;
      end
      UOP_WALK_B: begin
        cur_r <= p_rdata;
        rb_r  <= cur_r;
      end
      UOP_RD_RANK_B: rank_a_r <= r_rdata;
      UOP_MERGE: begin
        marks_r   <= marks_cut;
        removed_r <= 1'b1;
      end
      UOP_CLR_INIT: begin
        sweep_r   <= '0;
        marks_r   <= WALLS_BOTH;
        removed_r <= 1'b0;
        bad_r     <= 1'b0;
      end
      UOP_CLR_WRITE: sweep_r <= sweep_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == UOP_FINISH) && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == UOP_FINISH) && !out_busy) begin
      out_cell_r    <= cell_r;
      out_marks_r   <= marks_r;
      out_removed_r <= removed_r;
      out_bad_r     <= bad_r;
    end
  end

  assign status.no_item    = !in_tvalid;
  assign status.cmd        = cmd_r;
  assign status.bad        = bad_r;
  assign status.div_busy   = cnt_r != DIVC_W'(1);
  assign status.not_root   = p_rdata != cur_r;
  assign status.same       = ra_r == rb_r;
  assign status.sweep_busy = sweep_r != LAST_CELL;
  assign status.out_busy   = out_busy;

  assign out_valid   = out_valid_r;
  assign out_cell    = out_cell_r;
  assign out_marks   = out_marks_r;
  assign out_removed = out_removed_r;
  assign out_bad     = out_bad_r;

endmodule

// ===== hw/rtl/union_find_maze_carver_core.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata: cell_req, south_wall; tuser: cmd
// out_     out  out_tvalid/out_tready tdata: cell_out, wall_marks, removed, bad_wall
// cfg_     in   cfg_wr_en            cfg_wr_data: grid_side
//
// One item at a time. A wall inside the grid goes through the remainder unit and the
// two root walks before its result reaches out_tvalid; the next transfer in can follow
// once that result is in the output register.
// A clear command rewrites every cell before its result reaches out_tvalid.
// After reset a clearing pass holds in_tready low.
// A result waiting in the output register does not block the next transfer in.
module union_find_maze_carver_core #(
  parameter int MAX_CELLS = ufmc_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ufmc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [9:0] cell_req, [10] south_wall
  input  logic [ufmc_pkg::IN_TUSER_W-1:0]    in_tuser,   // [0] cmd
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ufmc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] cell_out, [11:10] wall_marks,
                                                         // [12] removed, [13] bad_wall
  input  logic                               cfg_wr_en,
  input  logic [ufmc_pkg::SIDE_W-1:0]        cfg_wr_data // grid_side
);
  import ufmc_pkg::*;

  localparam int OUT_PAD_W = OUT_TDATA_W - CELL_W - MARK_W - 2;

  logic [SIDE_W-1:0] grid_side_r;
  uword_t            ctrl;
  dp_status_t        status;
  logic [CELL_W-1:0] out_cell;
  logic [MARK_W-1:0] out_marks;
  logic              out_removed, out_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
    end else if (cfg_wr_en) begin
      grid_side_r <= cfg_wr_data;
    end
  end

  ufmc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ufmc_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .grid_side   (grid_side_r),
    .in_tvalid   (in_tvalid),
    .in_cmd      (in_tuser[0]),
    .in_cell     (in_tdata[CELL_W-1:0]),
    .in_south    (in_tdata[CELL_W]),
    .out_tready  (out_tready),
    .status      (status),
    .out_valid   (out_tvalid),
    .out_cell    (out_cell),
    .out_marks   (out_marks),
    .out_removed (out_removed),
    .out_bad     (out_bad)
  );

  assign in_tready = ctrl.op == UOP_ACCEPT;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_bad, out_removed, out_marks, out_cell};

endmodule

// ===== hw/rtl/ufmc_chk.sv =====
module ufmc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ufmc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ufmc_pkg::*;

  localparam int REMOVED_BIT = CELL_W + MARK_W;
  localparam int BAD_BIT     = CELL_W + MARK_W + 1;

  logic [MARK_W-1:0] marks;
  assign marks = out_tdata[CELL_W+MARK_W-1:CELL_W];

  // held result stays put until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_removed_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[REMOVED_BIT] && out_tdata[BAD_BIT]))
    else $error("wall both removed and bad");

  // a carved wall always leaves at least one mark cleared
  a_removed_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[REMOVED_BIT] |-> marks != WALLS_BOTH)
    else $error("removed wall still marked");

  // the clearing pass holds the block quiet after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity straight after reset");

endmodule

bind union_find_maze_carver_core ufmc_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ufmc_pkg::*;

  localparam int N_CELLS = MAX_CELLS_DEF;

  localparam logic CMD_WALL  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic DIR_EAST  = 1'b0;
  localparam logic DIR_SOUTH = 1'b1;

  localparam int RX_HOLD_CYCLES = 400;

  typedef struct packed {
    logic              cmd;
    logic [CELL_W-1:0] cell_id;
    logic              south;
  } wall_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic [MARK_W-1:0] marks;
    logic              removed;
    logic              bad;
  } carve_report_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [SIDE_W-1:0]      cfg_wr_data = '0;

  union_find_maze_carver_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  int unsigned       mdl_side;
  logic [CELL_W-1:0] mdl_parent [N_CELLS];
  logic [RANK_W-1:0] mdl_rank   [N_CELLS];
  logic [MARK_W-1:0] mdl_walls  [N_CELLS];

  wall_item_t    wall_queue[$];
  carve_report_t pending_reports[$];
  carve_report_t want;

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** union_find_maze_carver_core: FAILED **");
    $finish;
  end

  function automatic void reset_sets();
    for (int i = 0; i < N_CELLS; i++) begin
      mdl_parent[i] = CELL_W'(i);
      mdl_rank[i]   = '0;
      mdl_walls[i]  = WALLS_BOTH;
    end
  endfunction

  function automatic int unsigned find_root(int unsigned c);
    int unsigned hops;
    hops = 0;
    while (c < N_CELLS && mdl_parent[c] != c && hops < N_CELLS) begin
      c = 32'(mdl_parent[c]);
      hops++;
    end
    return c;
  endfunction

  function automatic carve_report_t carve_step(wall_item_t it);
    carve_report_t r;
    int unsigned   side, area, nb, ra, rb;
    r.cell_id = it.cell_id;
    r.marks   = '0;
    r.removed = 1'b0;
    r.bad     = 1'b0;
    side      = mdl_side;
    area      = side * side;
    nb        = 0;
    if (it.cmd == CMD_CLEAR) begin
      reset_sets();
      r.marks = WALLS_BOTH;
      return r;
    end
    if (it.cell_id >= area || it.cell_id >= N_CELLS) begin
      r.bad = 1'b1;
    end else begin
      r.marks = mdl_walls[it.cell_id];
      if (it.south == DIR_SOUTH) begin
        if (it.cell_id + side >= area) r.bad = 1'b1;
        else nb = it.cell_id + side;
      end else begin
        if (it.cell_id % side == side - 1) r.bad = 1'b1;
        else nb = it.cell_id + 1;
      end
      if (!r.bad && nb >= N_CELLS) r.bad = 1'b1;
      if (!r.bad) begin
        ra = find_root(it.cell_id);
        rb = find_root(nb);
        if (ra != rb && ra < N_CELLS && rb < N_CELLS) begin
          // union by rank, rank saturating
          if (mdl_rank[ra] < mdl_rank[rb]) begin
            mdl_parent[ra] = CELL_W'(rb);
          end else if (mdl_rank[ra] > mdl_rank[rb]) begin
            mdl_parent[rb] = CELL_W'(ra);
          end else begin
            mdl_parent[rb] = CELL_W'(ra);
            if (mdl_rank[ra] < RANK_MAX) mdl_rank[ra] = mdl_rank[ra] + 1'b1;
          end
          r.marks = r.marks & ~((it.south == DIR_SOUTH) ? WALL_SOUTH : WALL_EAST);
          mdl_walls[it.cell_id] = r.marks;
          r.removed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic wall_item_t make_wall(logic cmd, int unsigned cell_id, logic south);
    wall_item_t w;
    w.cmd     = cmd;
    w.cell_id = CELL_W'(cell_id);
    w.south   = south;
    return w;
  endfunction

  function automatic void push_wall(logic cmd, int unsigned cell_id, logic south);
    wall_queue.push_back(make_wall(cmd, cell_id, south));
  endfunction

  // mostly a shuffled list of the grid's own walls, with noise, edge walls and clears
  task automatic queue_random(int n);
    wall_item_t  deck[$];
    wall_item_t  tmp;
    int unsigned side, area, span;
    int          pick, j, roll;
    side = mdl_side;
    area = side * side;
    span = (area < N_CELLS) ? area : N_CELLS;
    for (int unsigned k = 0; k < span; k++) begin
      if (k % side != side - 1 && k + 1 < N_CELLS)
        deck.push_back(make_wall(CMD_WALL, k, DIR_EAST));
      if (k + side < area && k + side < N_CELLS)
        deck.push_back(make_wall(CMD_WALL, k, DIR_SOUTH));
    end
    pick = deck.size();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        push_wall(CMD_CLEAR, $urandom_range(N_CELLS - 1), 1'($urandom_range(1)));
      end else if (roll < 10 || deck.size() == 0) begin
        push_wall(CMD_WALL, $urandom_range(N_CELLS - 1), 1'($urandom_range(1)));
      end else if (roll < 18) begin
        push_wall(CMD_WALL, $urandom_range(span - 1), 1'($urandom_range(1)));
      end else begin
        if (pick == deck.size()) begin
          for (int k = deck.size() - 1; k > 0; k--) begin
            j       = $urandom_range(k);
            tmp     = deck[k];
            deck[k] = deck[j];
            deck[j] = tmp;
          end
          pick = 0;
        end
        wall_queue.push_back(deck[pick]);
        pick++;
      end
    end
  endtask

  task automatic wait_drain();
    while (wall_queue.size() != 0 || pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mdl_side = 32'(v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_reports.push_back(carve_step(wall_queue.pop_front()));
      end
      if (!in_tvalid || in_tready) begin
        if (wall_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'({wall_queue[0].south, wall_queue[0].cell_id});
          in_tuser  <= wall_queue[0].cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= RX_HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result with nothing expected: tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_tdata[9:0] !== want.cell_id) begin
            $error("cell_out: expected %0d, got %0d", want.cell_id, out_tdata[9:0]);
            mismatch_count++;
          end
          if (out_tdata[11:10] !== want.marks) begin
            $error("wall_marks: expected %0d, got %0d", want.marks, out_tdata[11:10]);
            mismatch_count++;
          end
          if (out_tdata[12] !== want.removed) begin
            $error("removed: expected %0d, got %0d", want.removed, out_tdata[12]);
            mismatch_count++;
          end
          if (out_tdata[13] !== want.bad) begin
            $error("bad_wall: expected %0d, got %0d", want.bad, out_tdata[13]);
            mismatch_count++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  int phase_side  [12] = '{5, 2, 32, 12, 63, 0, 1, 17, 33, 7, 31, 4};
  int phase_items [12] = '{120, 40, 150, 90, 70, 12, 12, 100, 60, 80, 80, 40};
  bit phase_clear [12] = '{1, 0, 1, 1, 0, 0, 0, 1, 0, 1, 1, 0};
  int idle_pct    [4]  = '{0, 51, 0, 33};
  int stall_pct   [4]  = '{0, 0, 51, 33};

  initial begin
    mdl_side = 32'(GRID_SIDE_RST);
    reset_sets();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset side of 32, merges, same set, edge walls, clears
    push_wall(CMD_WALL, 0, DIR_EAST);
    push_wall(CMD_WALL, 0, DIR_EAST);
    push_wall(CMD_WALL, 1, DIR_SOUTH);
    push_wall(CMD_WALL, 0, DIR_SOUTH);
    push_wall(CMD_WALL, 32, DIR_EAST);
    push_wall(CMD_WALL, 31, DIR_EAST);
    push_wall(CMD_WALL, 1023, DIR_EAST);
    push_wall(CMD_WALL, 1023, DIR_SOUTH);
    push_wall(CMD_WALL, 992, DIR_SOUTH);
    push_wall(CMD_WALL, 991, DIR_SOUTH);
    push_wall(CMD_WALL, 1022, DIR_EAST);
    push_wall(CMD_CLEAR, 1023, DIR_SOUTH);
    push_wall(CMD_WALL, 0, DIR_EAST);
    push_wall(CMD_CLEAR, 0, DIR_EAST);
    wait_drain();
    // side changed without a clear; cells past the grid
    write_side(3);
    push_wall(CMD_WALL, 9, DIR_EAST);
    push_wall(CMD_WALL, 8, DIR_EAST);
    push_wall(CMD_WALL, 6, DIR_SOUTH);
    push_wall(CMD_WALL, 4, DIR_EAST);
    push_wall(CMD_WALL, 1023, DIR_SOUTH);
    wait_drain();
    // neighbour beyond the store
    write_side(63);
    push_wall(CMD_WALL, 1023, DIR_EAST);
    push_wall(CMD_WALL, 960, DIR_SOUTH);
    push_wall(CMD_WALL, 961, DIR_SOUTH);
    wait_drain();
    write_side(0);
    push_wall(CMD_WALL, 0, DIR_EAST);
    wait_drain();
    write_side(1);
    push_wall(CMD_WALL, 0, DIR_SOUTH);
    push_wall(CMD_WALL, 0, DIR_EAST);
    wait_drain();

    for (int p = 0; p < 12; p++) begin
      send_idle_pct  = idle_pct[p % 4];
      recv_stall_pct = stall_pct[p % 4];
      write_side(SIDE_W'(phase_side[p]));
      if (phase_clear[p]) begin
        push_wall(CMD_CLEAR, $urandom_range(N_CELLS - 1), 1'($urandom_range(1)));
      end
      queue_random(phase_items[p] / 2);
      if (p == 2) hold_req = hold_req + 1;
      // sender waits here for every outstanding result
      wait_drain();
      queue_random(phase_items[p] - phase_items[p] / 2);
      wait_drain();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** union_find_maze_carver_core: PASSED **");
    end else begin
      $display("** union_find_maze_carver_core: FAILED **");
    end
    $finish;
  end

endmodule
